// ----- rtl/core/jsbd_pkg.sv -----
package jsbd_pkg;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_UNTERMINATED = 3'd1,
    ERR_CONTROL      = 3'd2,
    ERR_UTF8         = 3'd3,
    ERR_ESCAPE       = 3'd4,
    ERR_HEX          = 3'd5,
    ERR_INCOMPLETE   = 3'd6
  } err_t;

  typedef struct packed {
    logic        is_unit;
    logic [20:0] point;
    logic        done;
    err_t        err;
  } event_t;

endpackage

// ----- rtl/core/jsbd_front.sv -----
module jsbd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          byte_value,
  input  logic                end_of_text,
  output logic                push,
  output jsbd_pkg::event_t    ev
);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_ESCAPE,
    MODE_UTF8,
    MODE_HEX
  } mode_t;

  mode_t       mode, mode_next;
  logic [1:0]  pending, pending_next;
  logic [20:0] acc, acc_next;
  logic [3:0]  digit;
  logic        digit_ok;
  logic [15:0] hex_val;

  function automatic jsbd_pkg::event_t unit_ev(input logic [20:0] point);
    jsbd_pkg::event_t e;
    e.is_unit = 1'b1;
    e.point = point;
    e.done = 1'b0;
    e.err = jsbd_pkg::ERR_NONE;
    return e;
  endfunction

  function automatic jsbd_pkg::event_t end_ev(input logic done, input jsbd_pkg::err_t err);
    jsbd_pkg::event_t e;
    e.is_unit = 1'b0;
    e.point = '0;
    e.done = done;
    e.err = err;
    return e;
  endfunction

  always_comb begin
    digit = 4'd0;
    digit_ok = 1'b1;
    if (byte_value inside {[8'h30:8'h39]}) begin
      digit = 4'(byte_value - 8'h30);
    end else if (byte_value inside {[8'h61:8'h66]}) begin
      digit = 4'(byte_value - 8'h57);
    end else if (byte_value inside {[8'h41:8'h46]}) begin
      digit = 4'(byte_value - 8'h37);
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign hex_val = {acc[11:0], digit};

  always_comb begin
    mode_next = mode;
    pending_next = pending;
    acc_next = acc;
    push = 1'b0;
    ev = end_ev(1'b0, jsbd_pkg::ERR_NONE);
    if (accept) begin
      if (end_of_text) begin
        push = 1'b1;
        case (mode)
          MODE_UTF8: ev = end_ev(1'b0, jsbd_pkg::ERR_UTF8);
          MODE_HEX:  ev = end_ev(1'b0, jsbd_pkg::ERR_INCOMPLETE);
          default:   ev = end_ev(1'b0, jsbd_pkg::ERR_UNTERMINATED);
        endcase
        mode_next = MODE_PLAIN;
        pending_next = 2'd0;
        acc_next = '0;
      end else begin
        case (mode)
          MODE_PLAIN: begin
            if (byte_value == CH_QUOTE) begin
              push = 1'b1;
              ev = end_ev(1'b1, jsbd_pkg::ERR_NONE);
            end else if (byte_value < 8'h20) begin
              push = 1'b1;
              ev = end_ev(1'b0, jsbd_pkg::ERR_CONTROL);
            end else if (byte_value == CH_BSLASH) begin
              mode_next = MODE_ESCAPE;
            end else if (!byte_value[7]) begin
              push = 1'b1;
              ev = unit_ev({13'd0, byte_value});
            end else if (byte_value[7:5] == 3'b110) begin
              acc_next = {16'd0, byte_value[4:0]};
              pending_next = 2'd1;
              mode_next = MODE_UTF8;
            end else if (byte_value[7:4] == 4'b1110) begin
              acc_next = {17'd0, byte_value[3:0]};
              pending_next = 2'd2;
              mode_next = MODE_UTF8;
            end else if (byte_value[7:3] == 5'b11110) begin
              acc_next = {18'd0, byte_value[2:0]};
              pending_next = 2'd3;
              mode_next = MODE_UTF8;
            end else begin
              push = 1'b1;
              ev = end_ev(1'b0, jsbd_pkg::ERR_UTF8);
            end
          end
          MODE_ESCAPE: begin
            mode_next = MODE_PLAIN;
            push = 1'b1;
            case (byte_value)
              CH_QUOTE:  ev = unit_ev(21'h22);
              CH_BSLASH: ev = unit_ev(21'h5C);
              CH_SLASH:  ev = unit_ev(21'h2F);
              CH_B:      ev = unit_ev(21'h08);
              CH_F:      ev = unit_ev(21'h0C);
              CH_N:      ev = unit_ev(21'h0A);
              CH_R:      ev = unit_ev(21'h0D);
              CH_T:      ev = unit_ev(21'h09);
              CH_U: begin
                push = 1'b0;
                mode_next = MODE_HEX;
                pending_next = 2'd3;
                acc_next = '0;
              end
              default:   ev = end_ev(1'b0, jsbd_pkg::ERR_ESCAPE);
            endcase
          end
          MODE_UTF8: begin
            if (byte_value[7:6] != 2'b10) begin
              push = 1'b1;
              ev = end_ev(1'b0, jsbd_pkg::ERR_UTF8);
              mode_next = MODE_PLAIN;
              pending_next = 2'd0;
              acc_next = '0;
            end else if (pending <= 2'd1) begin
              push = 1'b1;
              ev = unit_ev({acc[14:0], byte_value[5:0]});
              mode_next = MODE_PLAIN;
              pending_next = 2'd0;
              acc_next = '0;
            end else begin
              acc_next = {acc[14:0], byte_value[5:0]};
              pending_next = pending - 2'd1;
            end
          end
          default: begin
            if (!digit_ok) begin
              push = 1'b1;
              ev = end_ev(1'b0, jsbd_pkg::ERR_HEX);
              mode_next = MODE_PLAIN;
              pending_next = 2'd0;
              acc_next = '0;
            end else if (pending == 2'd0) begin
              push = 1'b1;
              ev = unit_ev({5'd0, hex_val});
              mode_next = MODE_PLAIN;
              acc_next = '0;
            end else begin
              acc_next = {5'd0, hex_val};
              pending_next = pending - 2'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      pending <= 2'd0;
      acc <= '0;
    end else begin
      mode <= mode_next;
      pending <= pending_next;
      acc <= acc_next;
    end
  end

endmodule

// ----- rtl/core/jsbd_queue.sv -----
module jsbd_queue #(
  parameter int DEPTH = jsbd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jsbd_pkg::event_t push_ev,
  input  logic             pop,
  output jsbd_pkg::event_t head,
  output logic             head_valid,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsbd_pkg::event_t entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign head = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("transfer into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

// ----- rtl/core/jsbd_back.sv -----
module jsbd_back (
  input  logic             clk,
  input  logic             rst,
  input  jsbd_pkg::event_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [15:0]      code_unit,
  output logic             unit_valid,
  output logic             string_done,
  output logic [2:0]       error_code,
  output logic             last
);

  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [15:0] HIGH_BASE = 16'hD800;
  localparam logic [15:0] LOW_BASE = 16'hDC00;

  logic        second;
  logic        load;
  logic        big;
  logic [20:0] offset;
  logic [15:0] high_unit;
  logic [15:0] low_unit;

  assign load = !out_valid || !out_stall;
  assign big = head.is_unit && (head.point[20:16] != 5'd0);
  assign offset = head.point - SUPP_BASE;
  assign high_unit = HIGH_BASE + {5'd0, offset[20:10]};
  assign low_unit = LOW_BASE | {6'd0, offset[9:0]};
  assign pop = load && head_valid && !(big && !second);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        second <= big && !second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      unit_valid <= head.is_unit;
      string_done <= head.done;
      error_code <= head.err;
      last <= !(big && !second);
      if (!head.is_unit) begin
        code_unit <= '0;
      end else if (!big) begin
        code_unit <= head.point[15:0];
      end else if (!second) begin
        code_unit <= high_unit;
      end else begin
        code_unit <= low_unit;
      end
    end
  end

  a_second_holds_head: assert property (@(posedge clk) disable iff (rst)
    second |-> head_valid && big)
    else $error("pair second half without its entry");
  a_first_half_high: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (unit_valid && code_unit[15:11] == 5'b11011))
    else $error("non-final result is not a high surrogate");
  a_end_no_unit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !unit_valid) |-> last)
    else $error("done or error result not final");

endmodule

// ----- rtl/core/json_string_body_decoder.sv -----
// JSON string body decoder: feed the bytes after the opening quote, one per
// transfer, and read UTF-16 code units back. A closing quote yields a done
// result, any fault a single error result, and the next byte starts a new
// string. The input takes one byte per cycle; results leave one per cycle
// while out_stall is low, and a code point at or above 0x10000 yields two
// results (high then low surrogate). An accepted byte passes through the
// classifier into the event queue, then through the output register. The
// input stalls only while the event queue (QUEUE_DEPTH entries) is full.
module json_string_body_decoder #(
  parameter int QUEUE_DEPTH = jsbd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic        unit_valid,
  output logic        string_done,
  output logic [2:0]  error_code,
  output logic        last
);

  logic             accept;
  logic             push;
  logic             pop;
  logic             full;
  logic             head_valid;
  jsbd_pkg::event_t push_ev;
  jsbd_pkg::event_t head;

  assign in_stall = full;
  assign accept = in_valid && !full;

  jsbd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .byte_value  (byte_value),
    .end_of_text (end_of_text),
    .push        (push),
    .ev          (push_ev)
  );

  jsbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ev    (push_ev),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  jsbd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_unit   (code_unit),
    .unit_valid  (unit_valid),
    .string_done (string_done),
    .error_code  (error_code),
    .last        (last)
  );

endmodule

// ----- test/tb_json_string_body_decoder.sv -----
module tb_json_string_body_decoder;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] ESC_B        = 8'h62;
  localparam logic [7:0] ESC_F        = 8'h66;
  localparam logic [7:0] ESC_N        = 8'h6E;
  localparam logic [7:0] ESC_R        = 8'h72;
  localparam logic [7:0] ESC_T        = 8'h74;
  localparam logic [7:0] ESC_U        = 8'h75;

  localparam int TOTAL_ITEMS     = 1100;
  localparam int CALM_FROM       = 1000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES    = 20;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_ESCAPE,
    MODE_UTF8,
    MODE_HEX
  } decode_mode_t;

  typedef struct packed {
    logic [15:0]    unit;
    logic           valid;
    logic           done;
    jsbd_pkg::err_t err;
    logic           last;
  } unit_result_t;

  class utf16_unit_scoreboard;
    decode_mode_t mode;
    logic [1:0]   due;
    logic [20:0]  acc;
    unit_result_t awaited_units[$];
    int           mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      mode = MODE_PLAIN;
      due  = 2'd0;
      acc  = 21'd0;
    endfunction

    function void push(logic [15:0] u, logic v, logic d, jsbd_pkg::err_t e, logic l);
      unit_result_t r;
      r.unit  = u;
      r.valid = v;
      r.done  = d;
      r.err   = e;
      r.last  = l;
      awaited_units.push_back(r);
    endfunction

    function void close(logic d, jsbd_pkg::err_t e);
      clear();
      push(16'd0, 1'b0, d, e, 1'b1);
    endfunction

    function void emit_point(logic [20:0] cp);
      logic [20:0] off;
      if (cp >= 21'h10000) begin
        off = cp - 21'h10000;
        push(16'hD800 + {5'd0, off[20:10]}, 1'b1, 1'b0, jsbd_pkg::ERR_NONE, 1'b0);
        push(16'hDC00 + {6'd0, off[9:0]}, 1'b1, 1'b0, jsbd_pkg::ERR_NONE, 1'b1);
      end else begin
        push(cp[15:0], 1'b1, 1'b0, jsbd_pkg::ERR_NONE, 1'b1);
      end
    endfunction

    function bit hex_digit(logic [7:0] b, output logic [3:0] d);
      d = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
        d = b[3:0];
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
        d = b[3:0] + 4'd9;
      end else begin
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_byte(logic [7:0] b, logic eot);
      logic [3:0]  d;
      logic [20:0] cp;
      if (eot) begin
        case (mode)
          MODE_UTF8: close(1'b0, jsbd_pkg::ERR_UTF8);
          MODE_HEX:  close(1'b0, jsbd_pkg::ERR_INCOMPLETE);
          default:   close(1'b0, jsbd_pkg::ERR_UNTERMINATED);
        endcase
        return;
      end
      case (mode)
        MODE_PLAIN: begin
          if (b == CH_QUOTE) begin
            close(1'b1, jsbd_pkg::ERR_NONE);
          end else if (b < 8'h20) begin
            close(1'b0, jsbd_pkg::ERR_CONTROL);
          end else if (b == CH_BACKSLASH) begin
            mode = MODE_ESCAPE;
          end else if (b < 8'h80) begin
            emit_point({13'd0, b});
          end else if ((b & 8'hE0) == 8'hC0) begin
            acc  = {16'd0, b[4:0]};
            due  = 2'd1;
            mode = MODE_UTF8;
          end else if ((b & 8'hF0) == 8'hE0) begin
            acc  = {17'd0, b[3:0]};
            due  = 2'd2;
            mode = MODE_UTF8;
          end else if ((b & 8'hF8) == 8'hF0) begin
            acc  = {18'd0, b[2:0]};
            due  = 2'd3;
            mode = MODE_UTF8;
          end else begin
            close(1'b0, jsbd_pkg::ERR_UTF8);
          end
        end
        MODE_ESCAPE: begin
          mode = MODE_PLAIN;
          case (b)
            CH_QUOTE, CH_BACKSLASH, CH_SLASH: emit_point({13'd0, b});
            ESC_B: emit_point(21'h08);
            ESC_F: emit_point(21'h0C);
            ESC_N: emit_point(21'h0A);
            ESC_R: emit_point(21'h0D);
            ESC_T: emit_point(21'h09);
            ESC_U: begin
              mode = MODE_HEX;
              due  = 2'd3;
              acc  = 21'd0;
            end
            default: close(1'b0, jsbd_pkg::ERR_ESCAPE);
          endcase
        end
        MODE_UTF8: begin
          if (b[7:6] != 2'b10) begin
            close(1'b0, jsbd_pkg::ERR_UTF8);
          end else begin
            acc = {acc[14:0], b[5:0]};
            if (due <= 2'd1) begin
              cp = acc;
              clear();
              emit_point(cp);
            end else begin
              due = due - 2'd1;
            end
          end
        end
        default: begin
          if (!hex_digit(b, d)) begin
            close(1'b0, jsbd_pkg::ERR_HEX);
          end else begin
            acc = {5'd0, acc[11:0], d};
            if (due == 2'd0) begin
              cp = acc;
              clear();
              emit_point(cp);
            end else begin
              due = due - 2'd1;
            end
          end
        end
      endcase
    endfunction

    function void check_unit(logic [15:0] u, logic v, logic d, logic [2:0] e, logic l);
      unit_result_t want;
      if (awaited_units.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected result unit=%h valid=%b done=%b err=%0d last=%b",
                   u, v, d, e, l);
        return;
      end
      want = awaited_units.pop_front();
      if (u !== want.unit || v !== want.valid || d !== want.done ||
          e !== want.err || l !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected unit=%h valid=%b done=%b err=%0d last=%b",
                   want.unit, want.valid, want.done, want.err, want.last);
          $display("          got unit=%h valid=%b done=%b err=%0d last=%b",
                   u, v, d, e, l);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  byte_value;
  logic        end_of_text;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        string_done;
  logic [2:0]  error_code;
  logic        last;

  utf16_unit_scoreboard sb;
  int sent_items = 0;
  bit calm = 1'b0;
  bit hold_off_due = 1'b0;

  json_string_body_decoder u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .byte_value  (byte_value),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_unit   (code_unit),
    .unit_valid  (unit_valid),
    .string_done (string_done),
    .error_code  (error_code),
    .last        (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_byte(byte_value, end_of_text);
      if (out_valid && !out_stall)
        sb.check_unit(code_unit, unit_valid, string_done, error_code, last);
    end
  end

  task automatic offer(input logic [7:0] b, input logic eot);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    byte_value  <= b;
    end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    if (sent_items >= CALM_FROM)
      calm = 1'b1;
  endtask

  function automatic logic [7:0] hex_char(int v);
    if (v < 10)
      return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  function automatic logic [7:0] continuation();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  task automatic send_token();
    logic [7:0] b;
    int k;
    case ($urandom_range(0, 9))
      4: begin
        offer(CH_BACKSLASH, 1'b0);
        case ($urandom_range(0, 7))
          0: b = CH_QUOTE;
          1: b = CH_BACKSLASH;
          2: b = CH_SLASH;
          3: b = ESC_B;
          4: b = ESC_F;
          5: b = ESC_N;
          6: b = ESC_R;
          default: b = ESC_T;
        endcase
        offer(b, 1'b0);
      end
      5: begin
        offer(CH_BACKSLASH, 1'b0);
        offer(ESC_U, 1'b0);
        for (k = 0; k < 4; k++)
          offer(hex_char($urandom_range(0, 15)), 1'b0);
      end
      6: begin
        offer(8'hC0 | 8'($urandom_range(0, 31)), 1'b0);
        offer(continuation(), 1'b0);
      end
      7: begin
        offer(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
        for (k = 0; k < 2; k++)
          offer(continuation(), 1'b0);
      end
      8: begin
        offer(8'hF0 | 8'($urandom_range(0, 7)), 1'b0);
        for (k = 0; k < 3; k++)
          offer(continuation(), 1'b0);
      end
      default: begin
        do
          b = 8'($urandom_range(32, 127));
        while (b == CH_QUOTE || b == CH_BACKSLASH);
        offer(b, 1'b0);
      end
    endcase
  endtask

  task automatic send_fault();
    case ($urandom_range(0, 3))
      0: offer(8'($urandom_range(0, 255)), 1'b0);
      1: offer(8'($urandom_range(0, 255)), 1'b1);
      2: begin
        offer(CH_BACKSLASH, 1'b0);
        offer(ESC_U, 1'b0);
        offer(hex_char($urandom_range(0, 15)), 1'b0);
        offer(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      default: begin
        offer(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
        offer(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    endcase
  endtask

  task automatic send_string();
    int n;
    int cut;
    int i;
    n   = $urandom_range(0, 10);
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n) : -1;
    for (i = 0; i <= n; i++) begin
      if (i == cut) begin
        send_fault();
        return;
      end
      if (i < n)
        send_token();
    end
    offer(CH_QUOTE, 1'b0);
  endtask

  task automatic run_directed();
    offer(8'hF7, 1'b0);
    offer(8'hBF, 1'b0);
    offer(8'hBF, 1'b0);
    offer(8'hBF, 1'b0);
    offer(CH_BACKSLASH, 1'b0);
    offer(ESC_B, 1'b0);
    offer(8'h01, 1'b0);
    offer(CH_BACKSLASH, 1'b0);
    offer(8'h01, 1'b0);
    offer(8'hC2, 1'b0);
    offer(CH_QUOTE, 1'b0);
    offer(8'hFF, 1'b0);
    offer(8'h80, 1'b0);
    offer(CH_BACKSLASH, 1'b0);
    offer(ESC_U, 1'b0);
    offer(8'h47, 1'b0);
    offer(8'hE0, 1'b0);
    offer(8'hFF, 1'b1);
    offer(CH_BACKSLASH, 1'b0);
    offer(ESC_U, 1'b0);
    offer(8'h30, 1'b0);
    offer(8'h00, 1'b1);
    offer(8'h00, 1'b1);
    offer(8'h7F, 1'b0);
    offer(CH_QUOTE, 1'b0);
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    sb = new();
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    byte_value  <= 8'd0;
    end_of_text <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    hold_off_due = 1'b1;
    while (sent_items < TOTAL_ITEMS)
      send_string();
    in_valid <= 1'b0;
    while (sb.awaited_units.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
